// ===== design/alhpm_pkg.sv =====
// alhpm_pkg: shared types, constants and helpers of the audio level histogram peak meter
// no dependencies; used by every module of the block and by its checker

package alhpm_pkg;

    localparam int CHANNELS_DEFAULT = 8;
    localparam int NUM_BINS         = 16;
    localparam int BIN_W            = 4;
    localparam int SAMPLE_W         = 24;
    localparam int CNT_W            = 32;
    localparam int IN_W             = 32;
    localparam int OUT_W            = 320;

    localparam logic [SAMPLE_W-1:0] CLIP_LEVEL = 24'd8388096;
    localparam logic [CNT_W-1:0]    GAIN_MIN   = 32'd256;

    // floor(c * 2^23) for the level steps, loudest first
    localparam logic [SAMPLE_W-1:0] THRESH [7] = '{
        24'd7474249, 24'd6660554, 24'd5293211, 24'd3338665,
        24'd1325400, 24'd209715,  24'd8388
    };

    typedef enum logic [1:0] {
        OP_SAMPLE     = 2'd0,
        OP_READ       = 2'd1,
        OP_END_PERIOD = 2'd2,
        OP_RESET_ALL  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_DONE
    } div_state_t;

    // request from the top level to the histogram store
    typedef struct packed {
        logic valid;     // sample or read beat taken
        logic wr;        // sample: increment bin and channel count
        logic in_range;  // channel below the channel count
    } store_req_t;

    // status from the histogram store
    typedef struct packed {
        logic rd_valid;  // read data below is valid this cycle
        logic clearing;  // clearing pass running
    } store_rsp_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        sat_inc = (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // level bin of a sample: 0..7 positive loud to quiet, 8..15 negative quiet to loud
    function automatic logic [BIN_W-1:0] classify(input logic [SAMPLE_W-1:0] s);
        logic [SAMPLE_W-1:0] mag;
        logic                neg;
        logic                found;
        logic [2:0]          k;
        neg   = s[SAMPLE_W-1];
        mag   = neg ? (~s + SAMPLE_W'(1)) : s;
        found = 1'b0;
        k     = 3'd0;
        for (int i = 0; i < 7; i++)
        begin
            if (!found && (mag > THRESH[i]))
            begin
                found = 1'b1;
                k     = 3'(i);
            end
        end
        if (!neg)
            classify = found ? {1'b0, k} : 4'd7;
        else
            classify = found ? (4'd15 - {1'b0, k}) : 4'd8;
    endfunction

endpackage

// ===== design/audio_level_histogram_peak_meter.sv =====
// audio_level_histogram_peak_meter: top level of the level histogram and peak meter
// holds beat decode, peak and clip registers and the result register; uses alhpm_pkg,
// alhpm_store and alhpm_gain_div
//
//  channel   dir   width    fields (low bit first)
//  s_axis    in    32 + 2   tdata: sample, channel, bin_select, pad / tuser: operation
//  m_axis    out   320      tdata: bin_count .. max_gain, pad
//  cfg       in    1        cumulative_mode
//
//  a read beat runs the bit-serial gain divider, then hands its result to the result register;
//  s_axis_tready stays low until then, longer while an earlier result still waits on m_axis
//  end period (outside cumulative mode) and reset all start a clearing pass over all
//  16 * 2^CH_W bin memory entries (CH_W channel bits, at least 1), 128 at 8 channels
//  the same pass runs after rst_n; s_axis_tready stays low while it runs

module audio_level_histogram_peak_meter #(
    parameter int CHANNELS = alhpm_pkg::CHANNELS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // s_axis_tdata: sample[23:0], channel[26:24], bin_select[30:27], zero pad[31]
    input  logic [alhpm_pkg::IN_W-1:0]      s_axis_tdata,
    // s_axis_tuser: operation[1:0]
    input  logic [1:0]                      s_axis_tuser,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // m_axis_tdata: bin_count[31:0], channel_samples[63:32], peak_pos_all[86:64],
    // peak_neg_all[110:87], peak_pos_period[133:111], peak_neg_period[157:134],
    // clips_pos_all[189:158], clips_neg_all[221:190], clips_pos_period[253:222],
    // clips_neg_period[285:254], max_gain[317:286], zero pad[319:318]
    output logic [alhpm_pkg::OUT_W-1:0]     m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            cfg_wr_en,
    input  logic                            cfg_wr_data
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW    = alhpm_pkg::SAMPLE_W;
    localparam int CW    = alhpm_pkg::CNT_W;
    localparam logic [6:0] CH_LIMIT = 7'(CHANNELS);

    // beat fields
    logic [SW-1:0]               sample;
    logic [2:0]                  channel;
    logic [alhpm_pkg::BIN_W-1:0] bin_select;
    alhpm_pkg::op_t              operation;

    logic                        accept;
    logic                        in_range;
    logic                        is_neg;
    logic [SW-1:0]               mag;

    // decoded actions of the beat taken this cycle
    logic                        take_sample;
    logic                        take_read;
    logic                        clr_period;
    logic                        clr_all;

    alhpm_pkg::store_req_t       store_req;
    alhpm_pkg::store_rsp_t       store_rsp;
    logic [alhpm_pkg::BIN_W-1:0] store_bin;
    logic [CW-1:0]               store_rd_bin;
    logic [CW-1:0]               store_rd_cnt;

    logic                        div_done;
    logic [CW-1:0]               div_gain;
    logic [SW-1:0]               peak_max;
    logic                        out_load;

    logic                        cum_mode_reg;
    logic                        busy_reg;
    logic                        busy_next;
    logic [SW-2:0]               peak_pos_all_reg;
    logic [SW-1:0]               peak_neg_all_reg;
    logic [SW-2:0]               peak_pos_period_reg;
    logic [SW-1:0]               peak_neg_period_reg;
    logic [CW-1:0]               clips_pos_all_reg;
    logic [CW-1:0]               clips_neg_all_reg;
    logic [CW-1:0]               clips_pos_period_reg;
    logic [CW-1:0]               clips_neg_period_reg;
    logic [CW-1:0]               rd_bin_reg;
    logic [CW-1:0]               rd_cnt_reg;
    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [alhpm_pkg::OUT_W-1:0] m_data_reg;

    assign sample     = s_axis_tdata[23:0];
    assign channel    = s_axis_tdata[26:24];
    assign bin_select = s_axis_tdata[30:27];
    assign operation  = alhpm_pkg::op_t'(s_axis_tuser);

    // no beats while the clearing pass or a read is in flight
    assign s_axis_tready = !store_rsp.clearing && !busy_reg;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_range      = ({4'b0, channel} < CH_LIMIT);

    assign is_neg = sample[SW-1];
    assign mag    = is_neg ? (~sample + SW'(1)) : sample;

    always_comb
    begin
        take_sample = 1'b0;
        take_read   = 1'b0;
        clr_period  = 1'b0;
        clr_all     = 1'b0;
        if (accept)
        begin
            case (operation)
                alhpm_pkg::OP_SAMPLE:     take_sample = in_range;
                alhpm_pkg::OP_READ:       take_read   = 1'b1;
                alhpm_pkg::OP_END_PERIOD: clr_period  = !cum_mode_reg;
                alhpm_pkg::OP_RESET_ALL:
                begin
                    clr_period = 1'b1;
                    clr_all    = 1'b1;
                end
                default:
                begin
                    take_sample = 1'b0;
                end
            endcase
        end
    end

    // histogram store: sample beats increment, read beats fetch
    assign store_req.valid    = take_sample || take_read;
    assign store_req.wr       = take_sample;
    assign store_req.in_range = in_range;
    assign store_bin          = take_sample ? alhpm_pkg::classify(sample) : bin_select;

    alhpm_store #(
        .CHANNELS (CHANNELS)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (store_req),
        .req_bin     (store_bin),
        .req_ch      (CH_W'(channel)),
        .clear_start (clr_period),
        .rsp         (store_rsp),
        .rd_bin      (store_rd_bin),
        .rd_cnt      (store_rd_cnt)
    );

    // gain from the larger all-time peak; peaks stay put while the read is in flight
    assign peak_max = ({1'b0, peak_pos_all_reg} > peak_neg_all_reg)
                      ? {1'b0, peak_pos_all_reg} : peak_neg_all_reg;

    alhpm_gain_div u_gain_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (take_read),
        .divisor (peak_max),
        .ack     (out_load),
        .done    (div_done),
        .gain    (div_gain)
    );

    // result register parts the two sides
    assign out_load     = div_done && (!m_valid_reg || m_axis_tready);
    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);
    assign busy_next    = take_read ? 1'b1 : (out_load ? 1'b0 : busy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cum_mode_reg         <= 1'b0;
            busy_reg             <= 1'b0;
            m_valid_reg          <= 1'b0;
            peak_pos_all_reg     <= '0;
            peak_neg_all_reg     <= '0;
            peak_pos_period_reg  <= '0;
            peak_neg_period_reg  <= '0;
            clips_pos_all_reg    <= '0;
            clips_neg_all_reg    <= '0;
            clips_pos_period_reg <= '0;
            clips_neg_period_reg <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                cum_mode_reg <= cfg_wr_data;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;

            if (clr_all)
            begin
                peak_pos_all_reg  <= '0;
                peak_neg_all_reg  <= '0;
                clips_pos_all_reg <= '0;
                clips_neg_all_reg <= '0;
            end
            if (clr_period)
            begin
                peak_pos_period_reg  <= '0;
                peak_neg_period_reg  <= '0;
                clips_pos_period_reg <= '0;
                clips_neg_period_reg <= '0;
            end

            if (take_sample && !is_neg)
            begin
                if (sample[SW-2:0] > peak_pos_all_reg)
                    peak_pos_all_reg <= sample[SW-2:0];
                if (sample[SW-2:0] > peak_pos_period_reg)
                    peak_pos_period_reg <= sample[SW-2:0];
                if (sample >= alhpm_pkg::CLIP_LEVEL)
                begin
                    clips_pos_all_reg    <= alhpm_pkg::sat_inc(clips_pos_all_reg);
                    clips_pos_period_reg <= alhpm_pkg::sat_inc(clips_pos_period_reg);
                end
            end
            if (take_sample && is_neg)
            begin
                if (mag > peak_neg_all_reg)
                    peak_neg_all_reg <= mag;
                if (mag > peak_neg_period_reg)
                    peak_neg_period_reg <= mag;
                if (mag >= alhpm_pkg::CLIP_LEVEL)
                begin
                    clips_neg_all_reg    <= alhpm_pkg::sat_inc(clips_neg_all_reg);
                    clips_neg_period_reg <= alhpm_pkg::sat_inc(clips_neg_period_reg);
                end
            end
        end
    end

    // bin and channel count of the read, held until the gain is ready
    always_ff @(posedge clk)
    begin
        if (store_rsp.rd_valid)
        begin
            rd_bin_reg <= store_rd_bin;
            rd_cnt_reg <= store_rd_cnt;
        end
        if (out_load)
            m_data_reg <= {2'b00, div_gain,
                           clips_neg_period_reg, clips_pos_period_reg,
                           clips_neg_all_reg, clips_pos_all_reg,
                           peak_neg_period_reg, peak_pos_period_reg,
                           peak_neg_all_reg, peak_pos_all_reg,
                           rd_cnt_reg, rd_bin_reg};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

// ===== design/alhpm_store.sv =====
// alhpm_store: level bin memory and per-channel sample count memory
// read-modify-write with one forwarding stage and a clearing pass; uses alhpm_pkg

module alhpm_store #(
    parameter int CHANNELS = alhpm_pkg::CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  alhpm_pkg::store_req_t               req,
    input  logic [alhpm_pkg::BIN_W-1:0]         req_bin,
    input  logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] req_ch,
    input  logic                                clear_start,
    output alhpm_pkg::store_rsp_t               rsp,
    output logic [alhpm_pkg::CNT_W-1:0]         rd_bin,
    output logic [alhpm_pkg::CNT_W-1:0]         rd_cnt
);

    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int ADDR_W = alhpm_pkg::BIN_W + CH_W;
    localparam int CNT_W  = alhpm_pkg::CNT_W;

    logic [CNT_W-1:0] bin_mem [2**ADDR_W];
    logic [CNT_W-1:0] cnt_mem [2**CH_W];

    logic [CNT_W-1:0]  bin_rdata_reg;
    logic [CNT_W-1:0]  cnt_rdata_reg;

    logic              s1_valid_reg;
    logic              s1_wr_reg;
    logic              s1_in_range_reg;
    logic [ADDR_W-1:0] s1_addr_reg;

    logic              last_valid_reg;
    logic [ADDR_W-1:0] last_addr_reg;
    logic [CNT_W-1:0]  last_bin_reg;
    logic [CNT_W-1:0]  last_cnt_reg;

    logic              sweep_reg;
    logic              sweep_next;
    logic [ADDR_W-1:0] sweep_addr_reg;
    logic [ADDR_W-1:0] sweep_addr_next;

    logic [ADDR_W-1:0] req_addr;
    logic [CH_W-1:0]   s1_ch;
    logic [CNT_W-1:0]  bin_cur;
    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  bin_new;
    logic [CNT_W-1:0]  cnt_new;
    logic              do_write;

    assign req_addr = {req_bin, req_ch};
    assign s1_ch    = s1_addr_reg[CH_W-1:0];

    // the write of the previous cycle is not yet seen by a read issued alongside it
    assign bin_cur  = (last_valid_reg && (last_addr_reg == s1_addr_reg))
                      ? last_bin_reg : bin_rdata_reg;
    assign cnt_cur  = (last_valid_reg && (last_addr_reg[CH_W-1:0] == s1_ch))
                      ? last_cnt_reg : cnt_rdata_reg;
    assign bin_new  = alhpm_pkg::sat_inc(bin_cur);
    assign cnt_new  = alhpm_pkg::sat_inc(cnt_cur);
    assign do_write = s1_valid_reg && s1_wr_reg;

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
            bin_mem[sweep_addr_reg] <= '0;
        else if (do_write)
            bin_mem[s1_addr_reg] <= bin_new;
        bin_rdata_reg <= bin_mem[req_addr];
    end

    always_ff @(posedge clk)
    begin
        if (sweep_reg)
            cnt_mem[sweep_addr_reg[CH_W-1:0]] <= '0;
        else if (do_write)
            cnt_mem[s1_ch] <= cnt_new;
        cnt_rdata_reg <= cnt_mem[req_ch];
    end

    always_comb
    begin
        sweep_next      = sweep_reg;
        sweep_addr_next = sweep_addr_reg;
        if (sweep_reg)
        begin
            sweep_addr_next = sweep_addr_reg + ADDR_W'(1);
            if (sweep_addr_reg == '1)
                sweep_next = 1'b0;
        end
        else if (clear_start)
        begin
            sweep_next      = 1'b1;
            sweep_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg      <= 1'b1;
            sweep_addr_reg <= '0;
            s1_valid_reg   <= 1'b0;
            last_valid_reg <= 1'b0;
        end
        else
        begin
            sweep_reg      <= sweep_next;
            sweep_addr_reg <= sweep_addr_next;
            s1_valid_reg   <= req.valid;
            last_valid_reg <= do_write;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_wr_reg       <= req.wr;
        s1_in_range_reg <= req.in_range;
        s1_addr_reg     <= req_addr;
        last_addr_reg   <= s1_addr_reg;
        last_bin_reg    <= bin_new;
        last_cnt_reg    <= cnt_new;
    end

    assign rsp.rd_valid = s1_valid_reg && !s1_wr_reg;
    assign rsp.clearing = sweep_reg;
    assign rd_bin       = s1_in_range_reg ? bin_cur : '0;
    assign rd_cnt       = s1_in_range_reg ? cnt_cur : '0;

endmodule

// ===== design/alhpm_gain_div.sv =====
// alhpm_gain_div: restoring divider for the clip-free gain 2^31 / peak, one bit a cycle
// result floored at the minimum gain; uses alhpm_pkg

module alhpm_gain_div (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic [alhpm_pkg::SAMPLE_W-1:0]        divisor,
    input  logic                                  ack,
    output logic                                  done,
    output logic [alhpm_pkg::CNT_W-1:0]           gain
);

    localparam int SW     = alhpm_pkg::SAMPLE_W;
    localparam int QW     = alhpm_pkg::CNT_W;
    localparam int STEP_W = $clog2(QW);

    alhpm_pkg::div_state_t state_reg;
    alhpm_pkg::div_state_t state_next;

    logic [SW-1:0]            dvs_reg;
    logic [SW-1:0]            rem_reg;
    logic [QW-1:0]            quo_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     zero_reg;

    logic [SW-1:0]            rem_sh;
    logic                     ge;

    // dividend is 2^31: only its top bit is set
    assign rem_sh = {rem_reg[SW-2:0], (step_reg == '0)};
    assign ge     = (rem_sh >= dvs_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            alhpm_pkg::DIV_IDLE:
            begin
                if (start)
                    state_next = alhpm_pkg::DIV_RUN;
            end
            alhpm_pkg::DIV_RUN:
            begin
                if (step_reg == '1)
                    state_next = alhpm_pkg::DIV_DONE;
            end
            alhpm_pkg::DIV_DONE:
            begin
                if (ack)
                    state_next = alhpm_pkg::DIV_IDLE;
            end
            default:
                state_next = alhpm_pkg::DIV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= alhpm_pkg::DIV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == alhpm_pkg::DIV_IDLE)
        begin
            dvs_reg  <= divisor;
            zero_reg <= (divisor == '0);
            rem_reg  <= '0;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (state_reg == alhpm_pkg::DIV_RUN)
        begin
            rem_reg  <= ge ? (rem_sh - dvs_reg) : rem_sh;
            quo_reg  <= {quo_reg[QW-2:0], ge};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign done = (state_reg == alhpm_pkg::DIV_DONE);
    assign gain = (zero_reg || (quo_reg < alhpm_pkg::GAIN_MIN)) ? alhpm_pkg::GAIN_MIN : quo_reg;

endmodule

// ===== design/alhpm_checker.sv =====
// alhpm_checker: port-level assertions for audio_level_histogram_peak_meter
// bound to the top level below; uses alhpm_pkg

module alhpm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [1:0]                  s_axis_tuser,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [alhpm_pkg::OUT_W-1:0] m_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready
);

    logic s_beat;

    assign s_beat = s_axis_tvalid && s_axis_tready;

    // a read holds off the input while its gain is worked out
    a_read_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && (alhpm_pkg::op_t'(s_axis_tuser) == alhpm_pkg::OP_READ)) |=> !s_axis_tready)
        else $error("input ready straight after a read beat");

    // reset all starts the clearing pass
    a_reset_all_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s_beat && (alhpm_pkg::op_t'(s_axis_tuser) == alhpm_pkg::OP_RESET_ALL))
        |=> !s_axis_tready)
        else $error("input ready straight after a reset-all beat");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result beat dropped or changed while stalled");

    a_gain_floor: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[317:286] >= alhpm_pkg::GAIN_MIN))
        else $error("gain below the floor");

    // all-time figures never fall below the period ones
    a_all_ge_period: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((m_axis_tdata[86:64] >= m_axis_tdata[133:111])
                        && (m_axis_tdata[110:87] >= m_axis_tdata[157:134])
                        && (m_axis_tdata[189:158] >= m_axis_tdata[253:222])
                        && (m_axis_tdata[221:190] >= m_axis_tdata[285:254])))
        else $error("all-time figure below period figure");

endmodule

bind audio_level_histogram_peak_meter alhpm_checker u_alhpm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
